>>> design/sdc_pkg.sv
// Shared types and constants for the servo drive cycle controller.
`timescale 1ns / 1ps

package sdc_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_AUTORESET_PERIOD = 2'd0;
    localparam logic [1:0] CFG_AUTORESET_TRIES  = 2'd1;
    localparam logic [1:0] CFG_HOME_POSITION    = 2'd2;

    // Configuration reset values
    localparam logic [15:0] RST_AUTORESET_PERIOD = 16'd100;
    localparam logic [7:0]  RST_AUTORESET_TRIES  = 8'd3;
    localparam logic [31:0] RST_HOME_POSITION    = 32'd0;

    // Control word bit positions
    localparam int CTL_SWITCH_ON   = 0;
    localparam int CTL_VOLTAGE     = 1;
    localparam int CTL_NOT_QSTOP   = 2;
    localparam int CTL_ENABLE      = 3;
    localparam int CTL_FAULT_RESET = 7;
    localparam int CTL_HALT        = 8;

    // Status word bit positions
    localparam int SW_FAULT = 3;

    // Status flag bit positions
    localparam int ST_SWITCHED_ON = 1;

    typedef struct packed {
        logic               drive_operational;
        logic [15:0]        status_word;
        logic signed [31:0] actual_position;
        logic signed [31:0] external_encoder;
        logic               want_switch_on;
        logic               want_voltage;
        logic               want_quick_stop;
        logic               want_enable;
        logic               want_fault_reset;
        logic               want_halt;
        logic               clear_counts;
    } t_in;

    typedef struct packed {
        logic [8:0]         control_word;
        logic [10:0]        status_flags;
        logic               fault_out;
        logic signed [63:0] position_count;
        logic signed [63:0] encoder_count;
        logic signed [31:0] raw_position;
        logic               at_or_below_home;
        logic               at_or_above_home;
    } t_out;

    // Repack the raw status word into the flag layout
    function automatic logic [10:0] decode_status(input logic [15:0] sw);
        logic [10:0] st;
        st[0]  = sw[0];
        st[1]  = sw[1];
        st[2]  = sw[2];
        st[3]  = sw[4];
        st[4]  = ~sw[5];
        st[5]  = sw[6];
        st[6]  = sw[7];
        st[7]  = sw[9];
        st[8]  = sw[10];
        st[9]  = sw[11];
        st[10] = sw[12];
        return st;
    endfunction

endpackage

>>> design/sdc_ext_counter.sv
// Widens a wrapping 32-bit raw count into a wider wrapping counter.
`timescale 1ns / 1ps

module sdc_ext_counter #(
    parameter int COUNT_WIDTH = 64
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_clear,
    input  logic [31:0]            i_raw,
    output logic [COUNT_WIDTH-1:0] o_next
);

    logic [COUNT_WIDTH-1:0] r_count;
    logic [31:0]            r_prev;
    logic [31:0]            w_diff;
    logic [COUNT_WIDTH-1:0] n_count;

    // Delta since the last sample, sign extended, then accumulated
    assign w_diff  = i_raw - r_prev;
    assign n_count = i_clear ? '0 : r_count + COUNT_WIDTH'($signed(w_diff));
    assign o_next  = i_en ? n_count : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_prev  <= '0;
        end else if (i_en) begin
            r_count <= n_count;
            r_prev  <= i_raw;
        end
    end

endmodule

>>> design/servo_drive_cycle_controller.sv
// Top level: drive control word, status decode, fault autoreset and count extension.
`timescale 1ns / 1ps

// Each bus-cycle transaction passes through two registers in turn: an input register
// holds the transaction, the whole cycle update (status
// decode, autoreset timer, both count extensions, home compares, control word)
// runs in one pass, and a result register holds the outcome until taken.
// Sustained rate is one transaction per clock; o_in_ready drops only while both
// the input register and the result register are full and the result is not
// being taken. Configuration writes are
// always accepted and must be made while no transaction is in flight.
// COUNT_WIDTH (33..64) sets the width of the extended counters; reported
// counts are sign extended to 64 bits.
module servo_drive_cycle_controller #(
    parameter int COUNT_WIDTH = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  sdc_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output sdc_pkg::t_out o_out_data,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [1:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);

    // Configuration
    logic [15:0] r_period;
    logic [7:0]  r_tries;
    logic [31:0] r_home;

    // Pipeline
    logic          r_in_valid;
    sdc_pkg::t_in  r_in;
    logic          r_out_valid;
    sdc_pkg::t_out r_out;
    logic          w_advance;

    // Cycle state
    logic        r_first;
    logic        r_prev_sw;
    logic        r_faulted;
    logic [10:0] r_held_status;
    logic        r_held_fault;
    logic        r_held_below;
    logic        r_held_above;
    logic [31:0] r_held_raw;
    logic [7:0]  r_retries;
    logic        r_level;
    logic [15:0] r_timer;

    logic        n_faulted;
    logic [10:0] n_held_status;
    logic        n_held_fault;
    logic        n_held_below;
    logic        n_held_above;
    logic [31:0] n_held_raw;
    logic [7:0]  n_retries;
    logic        n_level;
    logic [15:0] n_timer;
    logic [8:0]  n_ctl;

    logic                   w_cnt_en;
    logic                   w_cnt_clear;
    logic [COUNT_WIDTH-1:0] w_pos_count;
    logic [COUNT_WIDTH-1:0] w_enc_count;

    assign w_advance   = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || w_advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign w_cnt_en    = w_advance && r_in.drive_operational;
    assign w_cnt_clear = r_first || r_in.clear_counts;

    sdc_ext_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_pos_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_cnt_en),
        .i_clear (w_cnt_clear),
        .i_raw   (r_in.actual_position),
        .o_next  (w_pos_count)
    );

    sdc_ext_counter #(.COUNT_WIDTH(COUNT_WIDTH)) u_enc_cnt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_cnt_en),
        .i_clear (w_cnt_clear),
        .i_raw   (r_in.external_encoder),
        .o_next  (w_enc_count)
    );

    always_comb begin
        n_faulted     = r_faulted;
        n_held_status = r_held_status;
        n_held_fault  = r_held_fault;
        n_held_below  = r_held_below;
        n_held_above  = r_held_above;
        n_held_raw    = r_held_raw;
        n_retries     = r_retries;
        n_level       = r_level;
        n_timer       = r_timer;

        // Read part: only while the drive is operational
        if (r_in.drive_operational) begin
            n_held_status = sdc_pkg::decode_status(r_in.status_word);
            n_faulted     = r_in.status_word[sdc_pkg::SW_FAULT];
            if (!n_faulted) begin
                n_retries = '0;
            end
            if (n_retries != '0) begin
                if (r_timer < r_period) begin
                    n_timer = r_timer + 16'd1;
                end else begin
                    n_timer = '0;
                    n_level = !r_level;
                    if (n_level) begin
                        n_retries = n_retries - 8'd1;
                    end
                end
                n_held_fault = 1'b0;
            end else begin
                n_held_fault = n_faulted;
            end
            n_held_raw   = r_in.actual_position;
            n_held_below = $signed(r_in.actual_position) <= $signed(r_home);
            n_held_above = $signed(r_home) <= $signed(r_in.actual_position);
        end

        // Arm the autoreset on a rising switch-on request while faulted
        if (r_tries != '0 && r_period != '0 && r_in.want_switch_on && !r_prev_sw
                && n_faulted) begin
            n_retries = r_tries;
            n_level   = 1'b1;
            n_timer   = '0;
        end

        n_ctl = '0;
        n_ctl[sdc_pkg::CTL_VOLTAGE]     = r_in.want_voltage;
        n_ctl[sdc_pkg::CTL_NOT_QSTOP]   = !r_in.want_quick_stop;
        n_ctl[sdc_pkg::CTL_FAULT_RESET] = r_in.want_fault_reset;
        n_ctl[sdc_pkg::CTL_HALT]        = r_in.want_halt;
        if (n_retries != '0) begin
            if (n_level) begin
                n_ctl[sdc_pkg::CTL_FAULT_RESET] = 1'b1;
            end
        end else begin
            n_ctl[sdc_pkg::CTL_SWITCH_ON] = r_in.want_switch_on;
            n_ctl[sdc_pkg::CTL_ENABLE]    = r_in.want_enable
                                          && n_held_status[sdc_pkg::ST_SWITCHED_ON];
        end
    end

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= sdc_pkg::RST_AUTORESET_PERIOD;
            r_tries  <= sdc_pkg::RST_AUTORESET_TRIES;
            r_home   <= sdc_pkg::RST_HOME_POSITION;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                sdc_pkg::CFG_AUTORESET_PERIOD: r_period <= i_cfg_data[15:0];
                sdc_pkg::CFG_AUTORESET_TRIES:  r_tries  <= i_cfg_data[7:0];
                sdc_pkg::CFG_HOME_POSITION:    r_home   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (w_advance) begin
            r_out.control_word     <= n_ctl;
            r_out.status_flags     <= n_held_status;
            r_out.fault_out        <= n_held_fault;
            r_out.position_count   <= 64'($signed(w_pos_count));
            r_out.encoder_count    <= 64'($signed(w_enc_count));
            r_out.raw_position     <= n_held_raw;
            r_out.at_or_below_home <= n_held_below;
            r_out.at_or_above_home <= n_held_above;
        end
    end

    // Cycle state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first       <= 1'b1;
            r_prev_sw     <= 1'b0;
            r_faulted     <= 1'b0;
            r_held_status <= '0;
            r_held_fault  <= 1'b0;
            r_held_below  <= 1'b0;
            r_held_above  <= 1'b0;
            r_held_raw    <= '0;
            r_retries     <= '0;
            r_level       <= 1'b0;
            r_timer       <= '0;
        end else if (w_advance) begin
            if (r_in.drive_operational) begin
                r_first <= 1'b0;
            end
            r_prev_sw     <= r_in.want_switch_on;
            r_faulted     <= n_faulted;
            r_held_status <= n_held_status;
            r_held_fault  <= n_held_fault;
            r_held_below  <= n_held_below;
            r_held_above  <= n_held_above;
            r_held_raw    <= n_held_raw;
            r_retries     <= n_retries;
            r_level       <= n_level;
            r_timer       <= n_timer;
        end
    end

endmodule

>>> design/sdc_checker.sv
// Port-level checks for the servo drive cycle controller, bound to the top level.
`timescale 1ns / 1ps

module sdc_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          o_in_ready,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input sdc_pkg::t_out o_out_data
);

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result dropped or changed while stalled");

    // Unused control word bits stay clear
    a_ctl_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.control_word[6:4] == 3'b000)
        else $error("reserved control word bits set");

    // Enable operation only when the drive reports switched on
    a_enable_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.control_word[sdc_pkg::CTL_ENABLE]
            |-> o_out_data.status_flags[sdc_pkg::ST_SWITCHED_ON])
        else $error("enable operation without switched on");

    // An empty result register means a transaction can be taken
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind servo_drive_cycle_controller sdc_checker u_sdc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
